// File: design/flash_key_value_log_store_unit_macros.svh
// Assertion macros used by the module that checks its own behavior.
`ifndef FLASH_KEY_VALUE_LOG_STORE_UNIT_MACROS_SVH
`define FLASH_KEY_VALUE_LOG_STORE_UNIT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define FKV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define FKV_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/fkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fkv_pkg;

  localparam int MAX_PAGES      = 4;
  localparam int WORDS_PER_PAGE = 256;
  localparam int PG_W           = $clog2(MAX_PAGES);
  localparam int OFF_W          = $clog2(WORDS_PER_PAGE);
  localparam int ADDR_W         = PG_W + OFF_W;
  localparam int FLASH_DEPTH    = MAX_PAGES * WORDS_PER_PAGE;

  localparam logic [31:0] WORD_ERASED  = 32'hffff_ffff;
  localparam logic [31:0] HDR_ACTIVE   = 32'hfffc_0000;
  localparam logic [31:0] HDR_COPY_IN  = 32'hfffe_0000;
  localparam logic [31:0] HDR_COPY_OUT = 32'hfff8_0000;
  localparam logic [15:0] KEY_ERASED   = 16'hffff;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_RECORD = 2'd2;
  localparam logic [1:0] ST_NO_PAGE   = 2'd3;

  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_COUNT  = 3'd2;
  localparam logic [2:0] REQ_INDEX  = 3'd3;
  localparam logic [2:0] REQ_FORMAT = 3'd4;

  localparam logic CFG_PAGES = 1'b0;
  localparam logic CFG_WORDS = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// File: design/fkv_flash.sv
`timescale 1ns / 1ps
`default_nettype none

module fkv_flash (
  input  wire logic              clk_i,
  input  wire fkv_pkg::mem_req_t req_i,
  output logic [31:0]            rdata_o
);

  logic [31:0] mem [fkv_pkg::FLASH_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end

endmodule

`default_nettype wire

// File: design/flash_key_value_log_store_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Key/value store kept in a page-organized flash array with a single port.
// Requests enter on the in channel (valid/ready) and each one returns exactly
// one beat on the out channel (valid/ready). The configuration port writes the
// page count and the page length; the user must do so only while the block is
// idle, as the block itself does not enforce it. After reset the block runs a
// clearing pass that erases the array and marks page 0 active; it accepts no
// request until that ends. One request is worked on at a time. Every flash
// word read takes a read state and a check state on the array port; count and
// read by index do a pairwise key scan, and a format erases every page in use.
// A write that finds the page full triggers compaction: a duplicate scan, a
// copy of the live keys with a lookup on the new page for each, and an erase
// of the old page, after which the write is tried again on the new page.
// The result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver only holds the block at its final step.

module flash_key_value_log_store_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [15:0] key_i,
  input  wire logic [15:0] in_value_i,
  input  wire logic [15:0] entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      out_key_o,
  output logic [15:0]      out_value_o,
  output logic [7:0]       key_count_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DONE,
    S_F_RD, S_F_CHK, S_F_RET,
    S_ST_PROG, S_E_RD, S_E_CHK, S_ST_END,
    S_D_ARD, S_D_ACHK, S_D_BRD, S_D_BCHK, S_D_NEXT,
    S_C_HRD, S_C_HCHK, S_C_SRD, S_C_SWR,
    S_CP_RD, S_CP_CHK, S_CP_NEXT,
    S_C_ARD, S_C_AWR, S_C_ERS,
    S_W_ARD, S_W_ACHK, S_W_BRD, S_W_BCHK, S_W_NEXT
  } state_e;

  typedef enum logic [1:0] {RET_READ, RET_STORE, RET_CPY} ret_e;
  typedef enum logic [1:0] {SR_MAIN1, SR_MAIN2, SR_COPY} sret_e;

  localparam int PG_W  = fkv_pkg::PG_W;
  localparam int OFF_W = fkv_pkg::OFF_W;
  localparam logic [OFF_W-1:0] OFF_ONE  = OFF_W'(1);
  localparam logic [OFF_W-1:0] OFF_TWO  = OFF_W'(2);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(fkv_pkg::WORDS_PER_PAGE - 1);

  state_e state_q;
  ret_e   ret_q;
  sret_e  sret_q;

  logic [2:0]  pages_q;
  logic [8:0]  words_q;
  logic [PG_W-1:0] active_q, src_q, dst_q, fpg_q;
  logic [OFF_W-1:0] a_q, b_q, fo_q;
  logic [fkv_pkg::ADDR_W-1:0] sweep_q, sweep_end_q;
  logic        fmt_q, found_q, st_ok_q, seek_q;
  logic [15:0] key_q, val_q, idx_q, fkey_q, sval_q, fval_q;
  logic [7:0]  cnt_q;
  logic [1:0]  r_status_q;
  logic [15:0] r_key_q, r_val_q;
  logic [7:0]  r_cnt_q;
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [15:0] out_key_q, out_val_q;
  logic [7:0]  out_cnt_q;

  logic [2:0]  np;
  logic [8:0]  nw;
  logic [OFF_W-1:0] last_off;
  logic [PG_W-1:0] next_pg;
  logic [31:0] rdata;
  logic [15:0] rd_key;
  logic        key_hit, rd_empty;
  logic [31:0] want;
  logic [7:0]  cnt_inc;
  fkv_pkg::mem_req_t mem_req;

  always_comb begin
    if (pages_q < 3'd2) begin
      np = 3'd2;
    end else if (pages_q > 3'(fkv_pkg::MAX_PAGES)) begin
      np = 3'(fkv_pkg::MAX_PAGES);
    end else begin
      np = pages_q;
    end
    if (words_q < 9'd2) begin
      nw = 9'd2;
    end else if (words_q > 9'(fkv_pkg::WORDS_PER_PAGE)) begin
      nw = 9'(fkv_pkg::WORDS_PER_PAGE);
    end else begin
      nw = words_q;
    end
  end

  assign last_off = OFF_W'(nw - 9'd1);
  assign next_pg  = (({1'b0, active_q} + 3'd1) < np) ? PG_W'(active_q + PG_W'(1)) : '0;
  assign rd_key   = rdata[31:16];
  assign key_hit  = rd_key == fkey_q;
  assign rd_empty = rd_key == fkv_pkg::KEY_ERASED;
  assign want     = {fkey_q, sval_q};
  assign cnt_inc  = cnt_q + 8'd1;

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = {active_q, a_q};
    mem_req.wdata = fkv_pkg::WORD_ERASED;
    unique case (state_q) inside
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = sweep_q;
        mem_req.wdata = (sweep_q == '0) ? fkv_pkg::HDR_ACTIVE : fkv_pkg::WORD_ERASED;
      end
      S_F_RD, S_E_RD: mem_req.addr = {fpg_q, b_q};
      S_E_CHK: begin
        mem_req.we    = rd_empty;
        mem_req.addr  = {fpg_q, b_q};
        mem_req.wdata = rdata & want;
      end
      S_ST_PROG: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = {fpg_q, fo_q};
        mem_req.wdata = want;
      end
      S_D_ARD, S_CP_RD: mem_req.addr = {src_q, a_q};
      S_D_BRD: mem_req.addr = {src_q, b_q};
      S_C_HRD, S_C_ARD: mem_req.addr = {dst_q, OFF_W'(0)};
      S_C_HCHK: begin
        mem_req.we    = rd_empty;
        mem_req.addr  = {dst_q, OFF_W'(0)};
        mem_req.wdata = rdata & fkv_pkg::HDR_COPY_IN;
      end
      S_C_SRD: mem_req.addr = {src_q, OFF_W'(0)};
      S_C_SWR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = {src_q, OFF_W'(0)};
        mem_req.wdata = rdata & fkv_pkg::HDR_COPY_OUT;
      end
      S_C_AWR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = {dst_q, OFF_W'(0)};
        mem_req.wdata = rdata & fkv_pkg::HDR_ACTIVE;
      end
      S_C_ERS: begin
        mem_req.we   = 1'b1;
        mem_req.addr = {src_q, b_q};
      end
      S_W_ARD: mem_req.addr = {active_q, a_q};
      S_W_BRD: mem_req.addr = {active_q, b_q};
      default: ;
    endcase
  end

  fkv_flash u_flash (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q <= 3'd2;
      words_q <= 9'd256;
    end else if (cfg_we_i) begin
      if (cfg_index_i == fkv_pkg::CFG_PAGES) begin
        pages_q <= cfg_data_i[2:0];
      end else begin
        words_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      ret_q        <= RET_READ;
      sret_q       <= SR_MAIN1;
      active_q     <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      fpg_q        <= '0;
      a_q          <= '0;
      b_q          <= '0;
      fo_q         <= '0;
      sweep_q      <= '0;
      sweep_end_q  <= '1;
      fmt_q        <= 1'b0;
      found_q      <= 1'b0;
      st_ok_q      <= 1'b0;
      seek_q       <= 1'b0;
      key_q        <= '0;
      val_q        <= '0;
      idx_q        <= '0;
      fkey_q       <= '0;
      sval_q       <= '0;
      fval_q       <= '0;
      cnt_q        <= '0;
      r_status_q   <= fkv_pkg::ST_OK;
      r_key_q      <= '0;
      r_val_q      <= '0;
      r_cnt_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= fkv_pkg::ST_OK;
      out_key_q    <= '0;
      out_val_q    <= '0;
      out_cnt_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (sweep_q == sweep_end_q) begin
            state_q <= fmt_q ? S_DONE : S_IDLE;
          end else begin
            sweep_q <= sweep_q + fkv_pkg::ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            key_q      <= key_i;
            val_q      <= in_value_i;
            idx_q      <= entry_index_i;
            r_status_q <= fkv_pkg::ST_OK;
            r_key_q    <= '0;
            r_val_q    <= '0;
            r_cnt_q    <= '0;
            fmt_q      <= 1'b0;
            case (req_type_i) inside
              fkv_pkg::REQ_READ: begin
                fpg_q   <= active_q;
                fkey_q  <= key_i;
                b_q     <= last_off;
                ret_q   <= RET_READ;
                state_q <= S_F_RD;
              end
              fkv_pkg::REQ_WRITE: begin
                fpg_q   <= active_q;
                fkey_q  <= key_i;
                sval_q  <= in_value_i;
                b_q     <= last_off;
                ret_q   <= RET_STORE;
                sret_q  <= SR_MAIN1;
                state_q <= S_F_RD;
              end
              fkv_pkg::REQ_COUNT, fkv_pkg::REQ_INDEX: begin
                seek_q  <= req_type_i == fkv_pkg::REQ_INDEX;
                a_q     <= last_off;
                cnt_q   <= '0;
                state_q <= S_W_ARD;
              end
              fkv_pkg::REQ_FORMAT: begin
                sweep_q     <= '0;
                sweep_end_q <= {PG_W'(np - 3'd1), OFF_LAST};
                fmt_q       <= 1'b1;
                active_q    <= '0;
                state_q     <= S_CLEAR;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= r_status_q;
            out_key_q    <= r_key_q;
            out_val_q    <= r_val_q;
            out_cnt_q    <= r_cnt_q;
            state_q      <= S_IDLE;
          end
        end
        S_F_RD: state_q <= S_F_CHK;
        S_F_CHK: begin
          if (key_hit) begin
            fo_q    <= b_q;
            fval_q  <= rdata[15:0];
            found_q <= 1'b1;
            state_q <= S_F_RET;
          end else if (b_q == OFF_ONE) begin
            found_q <= 1'b0;
            state_q <= S_F_RET;
          end else begin
            b_q     <= b_q - OFF_ONE;
            state_q <= S_F_RD;
          end
        end
        S_F_RET: begin
          unique case (ret_q)
            RET_READ: begin
              r_status_q <= found_q ? fkv_pkg::ST_OK : fkv_pkg::ST_NOT_FOUND;
              r_val_q    <= found_q ? fval_q : 16'd0;
              state_q    <= S_DONE;
            end
            RET_STORE: begin
              if (found_q && fval_q == sval_q) begin
                st_ok_q <= 1'b1;
                state_q <= S_ST_END;
              end else if (found_q && (fval_q & sval_q) == sval_q) begin
                state_q <= S_ST_PROG;
              end else begin
                b_q     <= OFF_ONE;
                state_q <= S_E_RD;
              end
            end
            RET_CPY: begin
              if (found_q) begin
                state_q <= S_CP_NEXT;
              end else begin
                b_q     <= OFF_ONE;
                sret_q  <= SR_COPY;
                state_q <= S_E_RD;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_ST_PROG: begin
          st_ok_q <= 1'b1;
          state_q <= S_ST_END;
        end
        S_E_RD: state_q <= S_E_CHK;
        S_E_CHK: begin
          if (rd_empty) begin
            st_ok_q <= 1'b1;
            state_q <= S_ST_END;
          end else if (b_q == last_off) begin
            st_ok_q <= 1'b0;
            state_q <= S_ST_END;
          end else begin
            b_q     <= b_q + OFF_ONE;
            state_q <= S_E_RD;
          end
        end
        S_ST_END: begin
          unique case (sret_q)
            SR_MAIN1: begin
              if (st_ok_q) begin
                r_status_q <= fkv_pkg::ST_OK;
                state_q    <= S_DONE;
              end else begin
                src_q <= active_q;
                dst_q <= next_pg;
                if (last_off < OFF_TWO) begin
                  r_status_q <= fkv_pkg::ST_NO_RECORD;
                  state_q    <= S_DONE;
                end else begin
                  a_q     <= last_off;
                  state_q <= S_D_ARD;
                end
              end
            end
            SR_MAIN2: begin
              r_status_q <= st_ok_q ? fkv_pkg::ST_OK : fkv_pkg::ST_NO_RECORD;
              state_q    <= S_DONE;
            end
            SR_COPY: begin
              if (st_ok_q) begin
                state_q <= S_CP_NEXT;
              end else begin
                r_status_q <= fkv_pkg::ST_NO_RECORD;
                state_q    <= S_DONE;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_D_ARD: state_q <= S_D_ACHK;
        S_D_ACHK: begin
          if (!rd_empty) begin
            fkey_q  <= rd_key;
            b_q     <= a_q - OFF_ONE;
            state_q <= S_D_BRD;
          end else begin
            state_q <= S_D_NEXT;
          end
        end
        S_D_BRD: state_q <= S_D_BCHK;
        S_D_BCHK: begin
          if (key_hit) begin
            state_q <= S_C_HRD;
          end else if (b_q == OFF_ONE) begin
            state_q <= S_D_NEXT;
          end else begin
            b_q     <= b_q - OFF_ONE;
            state_q <= S_D_BRD;
          end
        end
        S_D_NEXT: begin
          if (a_q == OFF_TWO) begin
            r_status_q <= fkv_pkg::ST_NO_RECORD;
            state_q    <= S_DONE;
          end else begin
            a_q     <= a_q - OFF_ONE;
            state_q <= S_D_ARD;
          end
        end
        S_C_HRD: state_q <= S_C_HCHK;
        S_C_HCHK: begin
          if (!rd_empty) begin
            r_status_q <= fkv_pkg::ST_NO_PAGE;
            state_q    <= S_DONE;
          end else begin
            state_q <= S_C_SRD;
          end
        end
        S_C_SRD: state_q <= S_C_SWR;
        S_C_SWR: begin
          a_q     <= last_off;
          state_q <= S_CP_RD;
        end
        S_CP_RD: state_q <= S_CP_CHK;
        S_CP_CHK: begin
          if (!rd_empty) begin
            fkey_q  <= rd_key;
            sval_q  <= rdata[15:0];
            fpg_q   <= dst_q;
            b_q     <= last_off;
            ret_q   <= RET_CPY;
            state_q <= S_F_RD;
          end else begin
            state_q <= S_CP_NEXT;
          end
        end
        S_CP_NEXT: begin
          if (a_q == OFF_ONE) begin
            state_q <= S_C_ARD;
          end else begin
            a_q     <= a_q - OFF_ONE;
            state_q <= S_CP_RD;
          end
        end
        S_C_ARD: state_q <= S_C_AWR;
        S_C_AWR: begin
          active_q <= dst_q;
          b_q      <= '0;
          state_q  <= S_C_ERS;
        end
        S_C_ERS: begin
          if (b_q == OFF_LAST) begin
            fpg_q   <= dst_q;
            fkey_q  <= key_q;
            sval_q  <= val_q;
            b_q     <= last_off;
            ret_q   <= RET_STORE;
            sret_q  <= SR_MAIN2;
            state_q <= S_F_RD;
          end else begin
            b_q <= b_q + OFF_ONE;
          end
        end
        S_W_ARD: state_q <= S_W_ACHK;
        S_W_ACHK: begin
          if (!rd_empty) begin
            if (seek_q && {9'd0, cnt_inc} == ({1'b0, idx_q} + 17'd1)) begin
              r_key_q    <= rd_key;
              r_val_q    <= rdata[15:0];
              r_status_q <= fkv_pkg::ST_OK;
              state_q    <= S_DONE;
            end else begin
              cnt_q  <= cnt_inc;
              fkey_q <= rd_key;
              if (a_q == OFF_ONE) begin
                state_q <= S_W_NEXT;
              end else begin
                b_q     <= a_q - OFF_ONE;
                state_q <= S_W_BRD;
              end
            end
          end else begin
            state_q <= S_W_NEXT;
          end
        end
        S_W_BRD: state_q <= S_W_BCHK;
        S_W_BCHK: begin
          if (key_hit) begin
            cnt_q   <= cnt_q - 8'd1;
            state_q <= S_W_NEXT;
          end else if (b_q == OFF_ONE) begin
            state_q <= S_W_NEXT;
          end else begin
            b_q     <= b_q - OFF_ONE;
            state_q <= S_W_BRD;
          end
        end
        S_W_NEXT: begin
          if (a_q == OFF_ONE) begin
            if (seek_q) begin
              r_status_q <= fkv_pkg::ST_NOT_FOUND;
            end else begin
              r_cnt_q <= cnt_q;
            end
            state_q <= S_DONE;
          end else begin
            a_q     <= a_q - OFF_ONE;
            state_q <= S_W_ARD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_key_o   = out_key_q;
  assign out_value_o = out_val_q;
  assign key_count_o = out_cnt_q;

`include "flash_key_value_log_store_unit_macros.svh"

  `FKV_ASSERT(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> !in_ready_o, "busy after accept")
  `FKV_ASSERT_NEVER(a_no_write_idle, mem_req.we && state_q == S_IDLE, "flash write while idle")
  `FKV_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "stray result")

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ERRS_SHOWN = 10;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [15:0] key_i = '0;
  logic [15:0] in_value_i = '0;
  logic [15:0] entry_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_key_o;
  logic [15:0] out_value_o;
  logic [7:0]  key_count_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;

  flash_key_value_log_store_unit dut (.*);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] okey;
    logic [15:0] oval;
    logic [7:0]  kcount;
  } answer_t;

  typedef struct {
    logic [2:0]  req;
    logic [15:0] key;
    logic [15:0] val;
    logic [15:0] idx;
    logic        fixed;
    answer_t     ans;
  } row_t;

  // Shadow of the store.
  logic [31:0] shadow_flash [fkv_pkg::FLASH_DEPTH];
  int unsigned shadow_active;
  int unsigned shadow_pages;
  int unsigned shadow_words;

  answer_t     pending_answers [$];
  int          mismatches = 0;
  longint      cycle_count = 0;
  bit          rx_idle_on = 1'b1;
  bit          keep_going = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[flash_key_value_log_store_unit] ERROR");
      $finish;
    end
  end

  function automatic int unsigned pages_eff();
    if (shadow_pages < 2) return 2;
    if (shadow_pages > fkv_pkg::MAX_PAGES) return fkv_pkg::MAX_PAGES;
    return shadow_pages;
  endfunction

  function automatic int unsigned words_eff();
    if (shadow_words < 2) return 2;
    if (shadow_words > fkv_pkg::WORDS_PER_PAGE) return fkv_pkg::WORDS_PER_PAGE;
    return shadow_words;
  endfunction

  function automatic int unsigned flat(int unsigned pg, int unsigned off);
    return (pg % fkv_pkg::MAX_PAGES) * fkv_pkg::WORDS_PER_PAGE
           + (off % fkv_pkg::WORDS_PER_PAGE);
  endfunction

  function automatic bit slot_free(logic [31:0] w);
    return w[31:16] == 16'hffff;
  endfunction

  function automatic int unsigned newest_slot(int unsigned pg, logic [15:0] k,
                                              output logic [15:0] v);
    for (int unsigned off = words_eff() - 1; off >= 1; off--) begin
      if (shadow_flash[flat(pg, off)][31:16] == k) begin
        v = shadow_flash[flat(pg, off)][15:0];
        return off;
      end
    end
    v = '0;
    return 0;
  endfunction

  function automatic logic [1:0] put_record(int unsigned pg, logic [15:0] k,
                                            logic [15:0] v);
    logic [15:0] old;
    logic [31:0] want;
    logic [31:0] have;
    int unsigned off;
    want = {k, v};
    off = newest_slot(pg, k, old);
    if (off != 0) begin
      have = {k, old};
      if (have == want) return fkv_pkg::ST_OK;
      if ((have & want) == want) begin
        shadow_flash[flat(pg, off)] &= want;
        return fkv_pkg::ST_OK;
      end
    end
    for (int unsigned o = 1; o < words_eff(); o++) begin
      if (slot_free(shadow_flash[flat(pg, o)])) begin
        shadow_flash[flat(pg, o)] &= want;
        return fkv_pkg::ST_OK;
      end
    end
    return fkv_pkg::ST_NO_RECORD;
  endfunction

  function automatic bit page_has_dup(int unsigned pg);
    logic [31:0] w;
    for (int unsigned a = words_eff() - 1; a > 1; a--) begin
      w = shadow_flash[flat(pg, a)];
      if (!slot_free(w)) begin
        for (int unsigned b = a - 1; b >= 1; b--) begin
          if (shadow_flash[flat(pg, b)][31:16] == w[31:16]) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void wipe_page(int unsigned pg);
    for (int unsigned i = 0; i < fkv_pkg::WORDS_PER_PAGE; i++) begin
      shadow_flash[flat(pg, i)] = fkv_pkg::WORD_ERASED;
    end
  endfunction

  function automatic logic [1:0] move_live_keys();
    int unsigned src;
    int unsigned dst;
    logic [31:0] w;
    logic [15:0] scratch;
    logic [1:0]  st;
    src = shadow_active;
    if (!page_has_dup(src)) return fkv_pkg::ST_NO_RECORD;
    dst = (src + 1 < pages_eff()) ? src + 1 : 0;
    if (!slot_free(shadow_flash[flat(dst, 0)])) return fkv_pkg::ST_NO_PAGE;
    shadow_flash[flat(src, 0)] &= fkv_pkg::HDR_COPY_OUT;
    shadow_flash[flat(dst, 0)] &= fkv_pkg::HDR_COPY_IN;
    for (int unsigned off = words_eff() - 1; off >= 1; off--) begin
      w = shadow_flash[flat(src, off)];
      if (!slot_free(w) && newest_slot(dst, w[31:16], scratch) == 0) begin
        st = put_record(dst, w[31:16], w[15:0]);
        if (st != fkv_pkg::ST_OK) return st;
      end
    end
    shadow_flash[flat(dst, 0)] &= fkv_pkg::HDR_ACTIVE;
    shadow_active = dst;
    wipe_page(src);
    return fkv_pkg::ST_OK;
  endfunction

  function automatic int unsigned walk_live(int unsigned target, bit seek,
                                            output logic [31:0] found);
    int unsigned cnt;
    logic [31:0] w;
    cnt = 0;
    found = '0;
    for (int unsigned a = words_eff() - 1; a >= 1; a--) begin
      w = shadow_flash[flat(shadow_active, a)];
      if (!slot_free(w)) begin
        cnt++;
        if (seek && cnt == target + 1) begin
          found = w;
          return 1;
        end
        for (int unsigned b = a - 1; b >= 1; b--) begin
          if (shadow_flash[flat(shadow_active, b)][31:16] == w[31:16]) begin
            cnt--;
            break;
          end
        end
      end
    end
    return seek ? 0 : cnt;
  endfunction

  function automatic answer_t predict_answer(logic [2:0] req, logic [15:0] k,
                                             logic [15:0] v, logic [15:0] idx);
    answer_t a;
    logic [31:0] w;
    logic [15:0] rv;
    int unsigned c;
    a = '0;
    case (req)
      fkv_pkg::REQ_READ: begin
        if (newest_slot(shadow_active, k, rv) == 0) a.status = fkv_pkg::ST_NOT_FOUND;
        a.oval = rv;
      end
      fkv_pkg::REQ_WRITE: begin
        a.status = put_record(shadow_active, k, v);
        if (a.status == fkv_pkg::ST_NO_RECORD) begin
          a.status = move_live_keys();
          if (a.status == fkv_pkg::ST_OK) a.status = put_record(shadow_active, k, v);
        end
      end
      fkv_pkg::REQ_COUNT: begin
        c = walk_live(0, 1'b0, w);
        a.kcount = (c > 255) ? 8'd255 : c[7:0];
      end
      fkv_pkg::REQ_INDEX: begin
        if (walk_live(idx, 1'b1, w) != 0) begin
          a.okey = w[31:16];
          a.oval = w[15:0];
        end else begin
          a.status = fkv_pkg::ST_NOT_FOUND;
        end
      end
      fkv_pkg::REQ_FORMAT: begin
        for (int unsigned p = 0; p < pages_eff(); p++) wipe_page(p);
        shadow_flash[flat(0, 0)] &= fkv_pkg::HDR_ACTIVE;
        shadow_active = 0;
      end
      default: ;
    endcase
    return a;
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, out_key_o, out_value_o, key_count_o};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_ERRS_SHOWN) $display("Unexpected beat: %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_ERRS_SHOWN) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic idx, int unsigned data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[8:0];
    if (idx == fkv_pkg::CFG_PAGES) shadow_pages = data & 7;
    else shadow_words = data & 9'h1ff;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (300000) @(negedge clk_i);
  endtask

  task automatic send_request(logic [2:0] req, logic [15:0] k, logic [15:0] v,
                              logic [15:0] idx, bit fixed, answer_t fixed_ans,
                              bit idle_on);
    answer_t pred;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    req_type_i <= req;
    key_i <= k;
    in_value_i <= v;
    entry_index_i <= idx;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = predict_answer(req, k, v, idx);
    pending_answers.push_back(fixed ? fixed_ans : pred);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [15:0] pick_val();
    case ($urandom_range(0, 3))
      0: return 16'hffff;
      1: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t rows [$];
    logic [2:0] r;
    int unsigned wsel;
    for (int i = 0; i < fkv_pkg::FLASH_DEPTH; i++) shadow_flash[i] = fkv_pkg::WORD_ERASED;
    shadow_flash[0] = fkv_pkg::HDR_ACTIVE;
    shadow_active = 0;
    shadow_pages = 2;
    shadow_words = 256;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(fkv_pkg::CFG_PAGES, 2);
    write_reg(fkv_pkg::CFG_WORDS, 6);
    rows = '{
      '{fkv_pkg::REQ_READ, 16'h0001, 16'h0000, 16'h0000, 1'b1,
        '{fkv_pkg::ST_NOT_FOUND, 0, 0, 0}},
      '{fkv_pkg::REQ_COUNT, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{fkv_pkg::ST_OK, 0, 0, 0}},
      '{fkv_pkg::REQ_INDEX, 16'h0000, 16'h0000, 16'hffff, 1'b1,
        '{fkv_pkg::ST_NOT_FOUND, 0, 0, 0}},
      '{fkv_pkg::REQ_WRITE, 16'h0000, 16'hffff, 16'h0000, 1'b1,
        '{fkv_pkg::ST_OK, 0, 0, 0}},
      '{fkv_pkg::REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{fkv_pkg::ST_OK, 0, 16'hffff, 0}},
      '{fkv_pkg::REQ_WRITE, 16'h0000, 16'h00f0, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_WRITE, 16'h0000, 16'h0f0f, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_WRITE, 16'hffff, 16'h1234, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_WRITE, 16'hfffe, 16'h0000, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_WRITE, 16'h0002, 16'h5555, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_WRITE, 16'h0003, 16'haaaa, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_WRITE, 16'h0004, 16'h0001, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_WRITE, 16'h0005, 16'h0002, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_COUNT, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{fkv_pkg::REQ_INDEX, 16'h0000, 16'h0000, 16'h0001, 1'b0, '0},
      '{fkv_pkg::REQ_INDEX, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{3'd5, 16'hffff, 16'hffff, 16'hffff, 1'b1,
        '{fkv_pkg::ST_OK, 0, 0, 0}},
      '{3'd7, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{fkv_pkg::ST_OK, 0, 0, 0}},
      '{fkv_pkg::REQ_FORMAT, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{fkv_pkg::ST_OK, 0, 0, 0}},
      '{fkv_pkg::REQ_COUNT, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{fkv_pkg::ST_OK, 0, 0, 0}}
    };
    foreach (rows[i]) begin
      send_request(rows[i].req, rows[i].key, rows[i].val, rows[i].idx,
                   rows[i].fixed, rows[i].ans, 1'b1);
    end

    // Pause until the store is quiet before changing geometry.
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(fkv_pkg::CFG_PAGES, 4); write_reg(fkv_pkg::CFG_WORDS, 2); end
        1: begin write_reg(fkv_pkg::CFG_PAGES, 3); write_reg(fkv_pkg::CFG_WORDS, 5); end
        2: begin write_reg(fkv_pkg::CFG_PAGES, 0); write_reg(fkv_pkg::CFG_WORDS, 9); end
        3: begin write_reg(fkv_pkg::CFG_PAGES, 7); write_reg(fkv_pkg::CFG_WORDS, 0); end
        4: begin write_reg(fkv_pkg::CFG_PAGES, 2); write_reg(fkv_pkg::CFG_WORDS, 4); end
        5: begin write_reg(fkv_pkg::CFG_PAGES, 4); write_reg(fkv_pkg::CFG_WORDS, 511); end
        6: begin write_reg(fkv_pkg::CFG_PAGES, 3); write_reg(fkv_pkg::CFG_WORDS, 8); end
        default: begin
          write_reg(fkv_pkg::CFG_PAGES, 4);
          write_reg(fkv_pkg::CFG_WORDS, 6);
        end
      endcase
      if (ph == 7) rx_idle_on = 1'b0;
      for (int n = 0; n < ((ph == 5) ? 25 : 65); n++) begin
        wsel = $urandom_range(0, 99);
        if (wsel < 55) r = fkv_pkg::REQ_WRITE;
        else if (wsel < 72) r = fkv_pkg::REQ_READ;
        else if (wsel < 82) r = fkv_pkg::REQ_COUNT;
        else if (wsel < 94) r = fkv_pkg::REQ_INDEX;
        else if (wsel < 97) r = fkv_pkg::REQ_FORMAT;
        else r = 3'($urandom_range(5, 7));
        send_request(r, pick_key(), pick_val(),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)),
                     1'b0, '0, ph != 7);
      end
      drain();
    end

    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("[flash_key_value_log_store_unit] OK");
    end else begin
      $display("[flash_key_value_log_store_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: flash_key_value_log_store_unit.f
+incdir+design
design/fkv_pkg.sv
design/fkv_flash.sv
design/flash_key_value_log_store_unit.sv
verif/tb_top.sv
